/* rtl/sid_pkg.sv */
// Shared definitions for the shallow-ice diffusivity pipeline.
// Holds binary32 constants, unit latencies, register indexes and a
// leading-zero counter used by the floating-point units. No dependencies.
package sid_pkg;

    localparam logic [31:0] QNAN        = 32'h7FC0_0000;
    localparam logic [31:0] ONE_HALF    = 32'h3F00_0000;
    localparam logic [31:0] ONE_QUARTER = 32'h3E80_0000;
    localparam logic [31:0] INV_SPACING_RST = 32'h3F80_0000;

    // Register stages of the adder and multiplier, and of the square root.
    localparam int FP_LAT   = 4;
    localparam int SQRT_LAT = 26;

    localparam int CFG_IDX_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_A_SCALED    = 4'd0,
        CFG_C_SCALED    = 4'd1,
        CFG_INV_SPACING = 4'd2,
        CFG_EPS_SQUARED = 4'd3
    } t_cfg_idx;

    // Result class decided early in a unit and applied at packing.
    typedef enum logic [1:0] {
        SP_NONE,
        SP_NAN,
        SP_INF,
        SP_ZERO
    } t_fspec;

    // Leading zeros of a 48-bit word; 48 when the word is zero.
    function automatic logic [5:0] f_lzc48(input logic [47:0] v);
        logic [5:0] n;
        n = 6'd48;
        for (int i = 0; i < 48; i++) begin
            if (v[i]) n = 6'(47 - i);
        end
        return n;
    endfunction

endpackage

/* rtl/sid_delay.sv */
// Enabled delay line for payload words that wait for a later pipeline stage.
// Depends on nothing.
module sid_delay #(
    parameter int W = 32,
    parameter int N = 4
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    generate
        if (N == 0) begin : g_none
            assign o_q = i_d;
        end else begin : g_line
            logic [W-1:0] r_tap [N];
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_tap[0] <= i_d;
                    for (int i = 1; i < N; i++) r_tap[i] <= r_tap[i-1];
                end
            end
            assign o_q = r_tap[N-1];
        end
    endgenerate

endmodule

/* rtl/sid_fmul.sv */
// Four-stage binary32 multiplier, round to nearest even, subnormals kept.
// Depends on sid_pkg.
module sid_fmul (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_p
);
    import sid_pkg::*;

    logic [7:0]  ea, eb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [23:0] ma, mb;
    t_fspec      n1_spec;
    logic signed [10:0] n1_enorm;

    logic [47:0] r1_prod;
    logic signed [10:0] r1_enorm;
    logic        r1_sign;
    t_fspec      r1_spec;

    logic [5:0]  lz;
    logic signed [10:0] diff, rsh;
    logic        n2_left;
    logic [5:0]  n2_amt;

    logic [47:0] r2_prod;
    logic        r2_left;
    logic [5:0]  r2_amt;
    logic signed [10:0] r2_eres;
    logic        r2_sign;
    t_fspec      r2_spec;

    logic [47:0] n3_m;
    logic        n3_stx;
    logic [47:0] r3_m;
    logic        r3_stx;
    logic signed [10:0] r3_eres;
    logic        r3_sign;
    t_fspec      r3_spec;

    logic        rnd, ovf;
    logic [7:0]  field;
    logic [30:0] mag;
    logic [31:0] n4_p, r4_p;

    always_comb begin
        ea = i_a[30:23];
        eb = i_b[30:23];
        a_nan  = (ea == 8'hFF) && (i_a[22:0] != '0);
        b_nan  = (eb == 8'hFF) && (i_b[22:0] != '0);
        a_inf  = (ea == 8'hFF) && (i_a[22:0] == '0);
        b_inf  = (eb == 8'hFF) && (i_b[22:0] == '0);
        a_zero = (i_a[30:0] == '0);
        b_zero = (i_b[30:0] == '0);
        ma = {ea != 8'd0, i_a[22:0]};
        mb = {eb != 8'd0, i_b[22:0]};
        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
            n1_spec = SP_NAN;
        end else if (a_inf || b_inf) begin
            n1_spec = SP_INF;
        end else if (a_zero || b_zero) begin
            n1_spec = SP_ZERO;
        end else begin
            n1_spec = SP_NONE;
        end
        n1_enorm = $signed({3'b0, (ea == 8'd0) ? 8'd1 : ea})
                 + $signed({3'b0, (eb == 8'd0) ? 8'd1 : eb}) - 11'sd126;
    end

    always_comb begin
        lz   = f_lzc48(r1_prod);
        diff = r1_enorm - $signed({5'b0, lz});
        rsh  = 11'sd1 - r1_enorm;
        if (diff >= 11'sd1) begin
            n2_left = 1'b1;
            n2_amt  = lz;
        end else if (r1_enorm >= 11'sd1) begin
            n2_left = 1'b1;
            n2_amt  = 6'(r1_enorm - 11'sd1);
        end else begin
            n2_left = 1'b0;
            n2_amt  = (rsh > 11'sd63) ? 6'd63 : rsh[5:0];
        end
    end

    always_comb begin
        if (r2_left) begin
            n3_m   = r2_prod << r2_amt;
            n3_stx = 1'b0;
        end else begin
            n3_m   = r2_prod >> r2_amt;
            n3_stx = |(r2_prod & ~({48{1'b1}} << r2_amt));
        end
    end

    always_comb begin
        rnd   = r3_m[23] & ((|r3_m[22:0]) | r3_stx | r3_m[24]);
        ovf   = r3_m[47] && (r3_eres >= 11'sd255);
        field = r3_m[47] ? r3_eres[7:0] : 8'd0;
        mag   = {field, r3_m[46:24]} + {30'd0, rnd};
        case (r3_spec)
            SP_NAN:  n4_p = QNAN;
            SP_INF:  n4_p = {r3_sign, 8'hFF, 23'd0};
            SP_ZERO: n4_p = {r3_sign, 31'd0};
            default: n4_p = ovf ? {r3_sign, 8'hFF, 23'd0} : {r3_sign, mag};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_prod  <= ma * mb;
            r1_enorm <= n1_enorm;
            r1_sign  <= i_a[31] ^ i_b[31];
            r1_spec  <= n1_spec;
            r2_prod  <= r1_prod;
            r2_left  <= n2_left;
            r2_amt   <= n2_amt;
            r2_eres  <= diff;
            r2_sign  <= r1_sign;
            r2_spec  <= r1_spec;
            r3_m     <= n3_m;
            r3_stx   <= n3_stx;
            r3_eres  <= r2_eres;
            r3_sign  <= r2_sign;
            r3_spec  <= r2_spec;
            r4_p     <= n4_p;
        end
    end

    assign o_p = r4_p;

endmodule

/* rtl/sid_fadd.sv */
// Four-stage binary32 adder, round to nearest even, subnormals kept.
// Depends on sid_pkg.
module sid_fadd (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_s
);
    import sid_pkg::*;

    logic [31:0] big, sml;
    logic [7:0]  eb, es, ebig, esml, d;
    logic [26:0] mb27, ms27, al;
    logic        a_nan, b_nan, a_inf, b_inf;
    t_fspec      n1_spec;

    logic [26:0] r1_big, r1_sml;
    logic [7:0]  r1_ebig;
    logic        r1_sub, r1_sign;
    t_fspec      r1_spec;

    logic [27:0] r2_sum;
    logic [7:0]  r2_ebig;
    logic        r2_sub, r2_sign;
    t_fspec      r2_spec;

    logic [5:0]  lz;
    logic [7:0]  lim;
    logic [4:0]  n3_amt;
    logic [8:0]  n3_e;
    logic [27:0] r3_sum;
    logic [4:0]  r3_amt;
    logic [8:0]  r3_e;
    logic        r3_sub, r3_sign;
    t_fspec      r3_spec;

    logic [26:0] m;
    logic        rnd, ovf;
    logic [7:0]  field;
    logic [30:0] mag;
    logic [31:0] n4_s, r4_s;

    always_comb begin
        a_nan = (i_a[30:23] == 8'hFF) && (i_a[22:0] != '0);
        b_nan = (i_b[30:23] == 8'hFF) && (i_b[22:0] != '0);
        a_inf = (i_a[30:23] == 8'hFF) && (i_a[22:0] == '0);
        b_inf = (i_b[30:23] == 8'hFF) && (i_b[22:0] == '0);
        if (a_nan || b_nan || (a_inf && b_inf && (i_a[31] != i_b[31]))) begin
            n1_spec = SP_NAN;
        end else if (a_inf || b_inf) begin
            n1_spec = SP_INF;
        end else begin
            n1_spec = SP_NONE;
        end
        // The larger magnitude always sits on the big side.
        if (i_b[30:0] > i_a[30:0]) begin
            big = i_b;
            sml = i_a;
        end else begin
            big = i_a;
            sml = i_b;
        end
        eb   = big[30:23];
        es   = sml[30:23];
        ebig = (eb == 8'd0) ? 8'd1 : eb;
        esml = (es == 8'd0) ? 8'd1 : es;
        d    = ebig - esml;
        mb27 = {eb != 8'd0, big[22:0], 3'b000};
        ms27 = {es != 8'd0, sml[22:0], 3'b000};
        if (d >= 8'd27) begin
            al = {26'd0, |ms27};
        end else begin
            al    = ms27 >> d;
            al[0] = al[0] | (|(ms27 & ~(27'h7FF_FFFF << d)));
        end
    end

    always_comb begin
        lz  = f_lzc48({r2_sum[26:0], 1'b1, 20'd0});
        lim = r2_ebig - 8'd1;
        n3_amt = ({2'b00, lz} < lim) ? lz[4:0] : lim[4:0];
        if (r2_sum[27]) begin
            n3_e = {1'b0, r2_ebig} + 9'd1;
        end else begin
            n3_e = {1'b0, r2_ebig} - {4'd0, n3_amt};
        end
    end

    always_comb begin
        if (r3_sum[27]) begin
            m = {r3_sum[27:2], r3_sum[1] | r3_sum[0]};
        end else begin
            m = r3_sum[26:0] << r3_amt;
        end
        rnd   = m[2] & (m[1] | m[0] | m[3]);
        ovf   = m[26] && (r3_e >= 9'd255);
        field = m[26] ? r3_e[7:0] : 8'd0;
        mag   = {field, m[25:3]} + {30'd0, rnd};
        case (r3_spec)
            SP_NAN:  n4_s = QNAN;
            SP_INF:  n4_s = {r3_sign, 8'hFF, 23'd0};
            default: begin
                if (r3_sum == '0) begin
                    // Exact cancellation gives +0; like-signed zeros keep the sign.
                    n4_s = {r3_sub ? 1'b0 : r3_sign, 31'd0};
                end else if (ovf) begin
                    n4_s = {r3_sign, 8'hFF, 23'd0};
                end else begin
                    n4_s = {r3_sign, mag};
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_big  <= mb27;
            r1_sml  <= al;
            r1_ebig <= ebig;
            r1_sub  <= i_a[31] ^ i_b[31];
            r1_sign <= big[31];
            r1_spec <= n1_spec;
            r2_sum  <= r1_sub ? ({1'b0, r1_big} - {1'b0, r1_sml})
                              : ({1'b0, r1_big} + {1'b0, r1_sml});
            r2_ebig <= r1_ebig;
            r2_sub  <= r1_sub;
            r2_sign <= r1_sign;
            r2_spec <= r1_spec;
            r3_sum  <= r2_sum;
            r3_amt  <= n3_amt;
            r3_e    <= n3_e;
            r3_sub  <= r2_sub;
            r3_sign <= r2_sign;
            r3_spec <= r2_spec;
            r4_s    <= n4_s;
        end
    end

    assign o_s = r4_s;

endmodule

/* rtl/sid_fsqrt.sv */
// Pipelined binary32 square root: one unpack stage, one restoring root bit
// per stage, and a rounding stage. Correctly rounded. Depends on sid_pkg.
module sid_fsqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    output logic [31:0] o_r
);
    import sid_pkg::*;

    localparam int NBIT = 24;

    logic [7:0]  e;
    logic [5:0]  lz;
    logic [23:0] m;
    logic signed [9:0] ex, exe, h;
    logic [24:0] x25;
    logic        n0_spec;
    logic [31:0] n0_sval;

    logic [25:0] r_rem  [NBIT+1];
    logic [23:0] r_root [NBIT+1];
    logic [47:0] r_rad  [NBIT+1];
    logic [7:0]  r_exh  [NBIT+1];
    logic        r_spec [NBIT+1];
    logic [31:0] r_sval [NBIT+1];

    logic        rnd;
    logic [31:0] n_out, r_out;

    always_comb begin
        e  = i_a[30:23];
        lz = f_lzc48({1'b0, i_a[22:0], 24'd0});
        if (e == 8'hFF) begin
            n0_spec = 1'b1;
            n0_sval = ((i_a[22:0] != '0) || i_a[31]) ? QNAN : i_a;
        end else if (i_a[30:0] == '0) begin
            n0_spec = 1'b1;
            n0_sval = i_a;
        end else if (i_a[31]) begin
            n0_spec = 1'b1;
            n0_sval = QNAN;
        end else begin
            n0_spec = 1'b0;
            n0_sval = i_a;
        end
        if (e == 8'd0) begin
            m  = {1'b0, i_a[22:0]} << lz[4:0];
            ex = -10'sd126 - $signed({4'd0, lz});
        end else begin
            m  = {1'b1, i_a[22:0]};
            ex = $signed({2'b00, e}) - 10'sd127;
        end
        x25 = ex[0] ? {m, 1'b0} : {1'b0, m};
        exe = ex[0] ? ex - 10'sd1 : ex;
        h   = (exe >>> 1) + 10'sd127;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_rad[0]  <= {x25, 23'd0};
            r_exh[0]  <= h[7:0];
            r_spec[0] <= n0_spec;
            r_sval[0] <= n0_sval;
        end
    end

    generate
        for (genvar k = 1; k <= NBIT; k++) begin : g_step
            logic [27:0] rs, t, df;
            logic        ge;
            always_comb begin
                rs = {r_rem[k-1], r_rad[k-1][47:46]};
                t  = {2'b00, r_root[k-1], 2'b01};
                df = rs - t;
                ge = (rs >= t);
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k]  <= ge ? df[25:0] : rs[25:0];
                    r_root[k] <= {r_root[k-1][22:0], ge};
                    r_rad[k]  <= {r_rad[k-1][45:0], 2'b00};
                    r_exh[k]  <= r_exh[k-1];
                    r_spec[k] <= r_spec[k-1];
                    r_sval[k] <= r_sval[k-1];
                end
            end
        end
    endgenerate

    always_comb begin
        // The remainder beats the root exactly when the true root lies above r + 1/2.
        rnd = r_rem[NBIT] > {2'b00, r_root[NBIT]};
        if (r_spec[NBIT]) begin
            n_out = r_sval[NBIT];
        end else begin
            n_out = {1'b0, r_exh[NBIT], 23'd0} + {9'd0, r_root[NBIT][22:0]}
                  + {31'd0, rnd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_out <= n_out;
    end

    assign o_r = r_out;

endmodule

/* rtl/shallow_ice_diffusivity.sv */
// Shallow-ice diffusivity pipeline, top level.
// Depends on sid_pkg, sid_delay, sid_fadd, sid_fmul and sid_fsqrt.
//
// Usage:
//   Each input beat is one grid cell's stencil: three ice thicknesses and
//   eight surface elevations, all binary32, plus a last-cell flag. Each beat
//   yields exactly one output beat with the east and north face
//   diffusivities and a copy of the flag, in the order the cells came in.
//   Both data channels use valid/stall; a beat moves when valid is high and
//   stall is low. The input stall is driven from the output stall, so the
//   whole pipeline freezes as one while the receiver holds off a waiting
//   result, and no beat is dropped or repeated.
//   Throughput is one cell per cycle while the output is not stalled. A beat
//   passes through ten dependent floating-point levels of four stages each,
//   with the 26-stage square root sitting in place of one of them on the
//   longest path.
//   The four coefficient registers are written through the configuration
//   channel, which is always ready; write them only while the pipeline is
//   empty. Reset clears the valid pipeline and loads the register defaults
//   (inverse spacing 1.0, everything else 0.0).
module shallow_ice_diffusivity (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_thick_center,
    input  logic [31:0] i_thick_east,
    input  logic [31:0] i_thick_north,
    input  logic [31:0] i_surf_center,
    input  logic [31:0] i_surf_east,
    input  logic [31:0] i_surf_west,
    input  logic [31:0] i_surf_north,
    input  logic [31:0] i_surf_south,
    input  logic [31:0] i_surf_northeast,
    input  logic [31:0] i_surf_southeast,
    input  logic [31:0] i_surf_northwest,
    input  logic        i_last_cell,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_east_coeff,
    output logic [31:0] o_north_coeff,
    output logic        o_last_out,

    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sid_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);
    import sid_pkg::*;

    localparam int L = FP_LAT;
    localparam int S = SQRT_LAT;
    // Ten arithmetic levels, the square root standing in for one of them.
    localparam int DEPTH = 9 * L + S;

    logic [31:0] r_a_scaled, r_c_scaled, r_inv_spacing, r_eps_squared;
    logic [DEPTH-1:0] r_vld;
    logic        en;

    // Configuration writes land directly; the datapath reads the registers live.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_scaled    <= '0;
            r_c_scaled    <= '0;
            r_inv_spacing <= INV_SPACING_RST;
            r_eps_squared <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_A_SCALED:    r_a_scaled    <= i_cfg_data;
                CFG_C_SCALED:    r_c_scaled    <= i_cfg_data;
                CFG_INV_SPACING: r_inv_spacing <= i_cfg_data;
                CFG_EPS_SQUARED: r_eps_squared <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The pipeline advances unless a finished result is being held off.
    assign en         = !(r_vld[DEPTH-1] && i_out_stall);
    assign o_in_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_in_valid};
        end
    end

    assign o_out_valid = r_vld[DEPTH-1];

    // Level 1: face sums and differences, quarter spacing.
    logic [31:0] a1, a2, a3, a4, a5, a6, q;
    sid_fadd u_a1 (.i_clk, .i_en(en), .i_a(i_thick_center), .i_b(i_thick_east),  .o_s(a1));
    sid_fadd u_a2 (.i_clk, .i_en(en), .i_a(i_thick_center), .i_b(i_thick_north), .o_s(a2));
    sid_fadd u_a3 (.i_clk, .i_en(en), .i_a(i_surf_east),
                   .i_b({~i_surf_center[31], i_surf_center[30:0]}), .o_s(a3));
    sid_fadd u_a4 (.i_clk, .i_en(en), .i_a(i_surf_north),
                   .i_b({~i_surf_center[31], i_surf_center[30:0]}), .o_s(a4));
    sid_fadd u_a5 (.i_clk, .i_en(en), .i_a(i_surf_east), .i_b(i_surf_northeast), .o_s(a5));
    sid_fadd u_a6 (.i_clk, .i_en(en), .i_a(i_surf_north),
                   .i_b({~i_surf_south[31], i_surf_south[30:0]}), .o_s(a6));
    sid_fmul u_q  (.i_clk, .i_en(en), .i_a(r_inv_spacing), .i_b(ONE_QUARTER), .o_p(q));

    logic [31:0] sw_d, sne_d, snw_d, sse_d, hc_d, he_d, hn_d, q_d;
    sid_delay #(.W(32), .N(L))   u_d_sw  (.i_clk, .i_en(en), .i_d(i_surf_west),      .o_q(sw_d));
    sid_delay #(.W(32), .N(L))   u_d_sne (.i_clk, .i_en(en), .i_d(i_surf_northeast), .o_q(sne_d));
    sid_delay #(.W(32), .N(2*L)) u_d_snw (.i_clk, .i_en(en), .i_d(i_surf_northwest), .o_q(snw_d));
    sid_delay #(.W(32), .N(2*L)) u_d_sse (.i_clk, .i_en(en), .i_d(i_surf_southeast), .o_q(sse_d));
    sid_delay #(.W(32), .N(2*L)) u_d_hc  (.i_clk, .i_en(en), .i_d(i_thick_center),   .o_q(hc_d));
    sid_delay #(.W(32), .N(2*L)) u_d_he  (.i_clk, .i_en(en), .i_d(i_thick_east),     .o_q(he_d));
    sid_delay #(.W(32), .N(2*L)) u_d_hn  (.i_clk, .i_en(en), .i_d(i_thick_north),    .o_q(hn_d));
    sid_delay #(.W(32), .N(2*L)) u_d_q   (.i_clk, .i_en(en), .i_d(q),                .o_q(q_d));

    // Level 2: mid thicknesses, direct slopes, partial cross sums.
    logic [31:0] hmid_e, hmid_n, gx_e, gy_n, b5, b6;
    sid_fmul u_hme (.i_clk, .i_en(en), .i_a(a1), .i_b(ONE_HALF),      .o_p(hmid_e));
    sid_fmul u_hmn (.i_clk, .i_en(en), .i_a(a2), .i_b(ONE_HALF),      .o_p(hmid_n));
    sid_fmul u_gxe (.i_clk, .i_en(en), .i_a(a3), .i_b(r_inv_spacing), .o_p(gx_e));
    sid_fmul u_gyn (.i_clk, .i_en(en), .i_a(a4), .i_b(r_inv_spacing), .o_p(gy_n));
    sid_fadd u_b5  (.i_clk, .i_en(en), .i_a(a5), .i_b({~sw_d[31], sw_d[30:0]}), .o_s(b5));
    sid_fadd u_b6  (.i_clk, .i_en(en), .i_a(a6), .i_b(sne_d), .o_s(b6));

    // Upwind thickness: the east or north neighbor only for a strictly positive
    // slope; zero and NaN slopes fall back to the center cell.
    logic        pos_e, pos_n;
    logic [31:0] hup_e, hup_n;
    always_comb begin
        pos_e = !gx_e[31] && (gx_e[30:0] != '0)
                && !((gx_e[30:23] == 8'hFF) && (gx_e[22:0] != '0));
        pos_n = !gy_n[31] && (gy_n[30:0] != '0)
                && !((gy_n[30:23] == 8'hFF) && (gy_n[22:0] != '0));
        hup_e = pos_e ? he_d : hc_d;
        hup_n = pos_n ? hn_d : hc_d;
    end

    // Level 3: squares, scaled upwind thickness, finished cross sums.
    logic [31:0] m2e, m2n, gxe2, gyn2, ahe, che, ahn, chn, c5, c6;
    sid_fmul u_m2e  (.i_clk, .i_en(en), .i_a(hmid_e),     .i_b(hmid_e), .o_p(m2e));
    sid_fmul u_m2n  (.i_clk, .i_en(en), .i_a(hmid_n),     .i_b(hmid_n), .o_p(m2n));
    sid_fmul u_gxe2 (.i_clk, .i_en(en), .i_a(gx_e),       .i_b(gx_e),   .o_p(gxe2));
    sid_fmul u_gyn2 (.i_clk, .i_en(en), .i_a(gy_n),       .i_b(gy_n),   .o_p(gyn2));
    sid_fmul u_ahe  (.i_clk, .i_en(en), .i_a(r_a_scaled), .i_b(hup_e),  .o_p(ahe));
    sid_fmul u_che  (.i_clk, .i_en(en), .i_a(r_c_scaled), .i_b(hup_e),  .o_p(che));
    sid_fmul u_ahn  (.i_clk, .i_en(en), .i_a(r_a_scaled), .i_b(hup_n),  .o_p(ahn));
    sid_fmul u_chn  (.i_clk, .i_en(en), .i_a(r_c_scaled), .i_b(hup_n),  .o_p(chn));
    sid_fadd u_c5   (.i_clk, .i_en(en), .i_a(b5), .i_b({~snw_d[31], snw_d[30:0]}), .o_s(c5));
    sid_fadd u_c6   (.i_clk, .i_en(en), .i_a(b6), .i_b({~sse_d[31], sse_d[30:0]}), .o_s(c6));

    // Level 4: cross slopes, fourth powers, sliding products.
    logic [31:0] gxn, gye, m4e, m4n, cme, cmn;
    sid_fmul u_gxn (.i_clk, .i_en(en), .i_a(c5),  .i_b(q_d), .o_p(gxn));
    sid_fmul u_gye (.i_clk, .i_en(en), .i_a(c6),  .i_b(q_d), .o_p(gye));
    sid_fmul u_m4e (.i_clk, .i_en(en), .i_a(m2e), .i_b(m2e), .o_p(m4e));
    sid_fmul u_m4n (.i_clk, .i_en(en), .i_a(m2n), .i_b(m2n), .o_p(m4n));
    sid_fmul u_cme (.i_clk, .i_en(en), .i_a(che), .i_b(m2e), .o_p(cme));
    sid_fmul u_cmn (.i_clk, .i_en(en), .i_a(chn), .i_b(m2n), .o_p(cmn));

    logic [31:0] ahe_d, ahn_d, gxe2_d, gyn2_d;
    sid_delay #(.W(32), .N(L))   u_d_ahe  (.i_clk, .i_en(en), .i_d(ahe),  .o_q(ahe_d));
    sid_delay #(.W(32), .N(L))   u_d_ahn  (.i_clk, .i_en(en), .i_d(ahn),  .o_q(ahn_d));
    sid_delay #(.W(32), .N(2*L)) u_d_gxe2 (.i_clk, .i_en(en), .i_d(gxe2), .o_q(gxe2_d));
    sid_delay #(.W(32), .N(2*L)) u_d_gyn2 (.i_clk, .i_en(en), .i_d(gyn2), .o_q(gyn2_d));

    // Level 5: cross slope squares, flow products.
    logic [31:0] gxn2, gye2, ame, amn;
    sid_fmul u_gxn2 (.i_clk, .i_en(en), .i_a(gxn),   .i_b(gxn), .o_p(gxn2));
    sid_fmul u_gye2 (.i_clk, .i_en(en), .i_a(gye),   .i_b(gye), .o_p(gye2));
    sid_fmul u_ame  (.i_clk, .i_en(en), .i_a(ahe_d), .i_b(m4e), .o_p(ame));
    sid_fmul u_amn  (.i_clk, .i_en(en), .i_a(ahn_d), .i_b(m4n), .o_p(amn));

    // Levels 6 and 7: squared slope magnitude plus regularization.
    logic [31:0] sume, sumn, s2e, s2n;
    sid_fadd u_sume (.i_clk, .i_en(en), .i_a(gxe2_d), .i_b(gye2),   .o_s(sume));
    sid_fadd u_sumn (.i_clk, .i_en(en), .i_a(gxn2),   .i_b(gyn2_d), .o_s(sumn));
    sid_fadd u_s2e  (.i_clk, .i_en(en), .i_a(sume), .i_b(r_eps_squared), .o_s(s2e));
    sid_fadd u_s2n  (.i_clk, .i_en(en), .i_a(sumn), .i_b(r_eps_squared), .o_s(s2n));

    logic [31:0] ame_d, amn_d, cme_d, cmn_d;
    sid_delay #(.W(32), .N(2*L))   u_d_ame (.i_clk, .i_en(en), .i_d(ame), .o_q(ame_d));
    sid_delay #(.W(32), .N(2*L))   u_d_amn (.i_clk, .i_en(en), .i_d(amn), .o_q(amn_d));
    sid_delay #(.W(32), .N(3*L+S)) u_d_cme (.i_clk, .i_en(en), .i_d(cme), .o_q(cme_d));
    sid_delay #(.W(32), .N(3*L+S)) u_d_cmn (.i_clk, .i_en(en), .i_d(cmn), .o_q(cmn_d));

    // Level 8: square roots, in parallel with the flow terms.
    logic [31:0] sqe, sqn, t1e, t1n, t1e_d, t1n_d;
    sid_fsqrt u_sqe (.i_clk, .i_en(en), .i_a(s2e), .o_r(sqe));
    sid_fsqrt u_sqn (.i_clk, .i_en(en), .i_a(s2n), .o_r(sqn));
    sid_fmul  u_t1e (.i_clk, .i_en(en), .i_a(ame_d), .i_b(s2e), .o_p(t1e));
    sid_fmul  u_t1n (.i_clk, .i_en(en), .i_a(amn_d), .i_b(s2n), .o_p(t1n));
    sid_delay #(.W(32), .N(S)) u_d_t1e (.i_clk, .i_en(en), .i_d(t1e), .o_q(t1e_d));
    sid_delay #(.W(32), .N(S)) u_d_t1n (.i_clk, .i_en(en), .i_d(t1n), .o_q(t1n_d));

    // Level 9: sliding terms. Level 10: final sums, whose output
    // registers are the result registers.
    logic [31:0] t2e, t2n;
    sid_fmul u_t2e (.i_clk, .i_en(en), .i_a(cme_d), .i_b(sqe), .o_p(t2e));
    sid_fmul u_t2n (.i_clk, .i_en(en), .i_a(cmn_d), .i_b(sqn), .o_p(t2n));
    sid_fadd u_de  (.i_clk, .i_en(en), .i_a(t1e_d), .i_b(t2e), .o_s(o_east_coeff));
    sid_fadd u_dn  (.i_clk, .i_en(en), .i_a(t1n_d), .i_b(t2n), .o_s(o_north_coeff));

    sid_delay #(.W(1), .N(DEPTH)) u_d_last (
        .i_clk, .i_en(en), .i_d(i_last_cell), .o_q(o_last_out)
    );

endmodule
